>>> src/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and the lead byte classifier of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int unsigned CP_W        = 31;
	localparam int unsigned HELD_DEPTH  = 5;
	localparam int unsigned HELD_IDX_W  = 3;

	// Continuations a lead byte calls for; the two special codes sit outside 1..5.
	localparam logic [2:0] NEED_ASCII = 3'd0;
	localparam logic [2:0] NEED_STRAY = 3'd6;

	localparam logic [7:0] LEAD_ASCII_END = 8'h80;
	localparam logic [7:0] LEAD_2_START   = 8'hc2;
	localparam logic [7:0] LEAD_3_START   = 8'he0;
	localparam logic [7:0] LEAD_4_START   = 8'hf0;
	localparam logic [7:0] LEAD_5_START   = 8'hf8;
	localparam logic [7:0] LEAD_6_START   = 8'hfc;
	localparam logic [7:0] LEAD_6_END     = 8'hfe;
	localparam logic [1:0] CONT_TAG       = 2'b10;

	typedef enum logic {
		ST_IDLE,
		ST_REPLAY
	} state_t;

	typedef struct packed {
		logic [2:0] need;
		logic [6:0] payload;
	} lead_info_t;

	typedef struct packed {
		logic [7:0]      byte_value;
		logic [2:0]      rem;
		logic [CP_W-1:0] acc;
		logic            bad;
		logic            limited;
		logic [2:0]      avail;
	} step_req_t;

	typedef struct packed {
		logic            emit;
		logic [CP_W-1:0] code_point;
		logic            malformed;
		logic [2:0]      rem_n;
		logic [CP_W-1:0] acc_n;
		logic            bad_n;
	} step_res_t;

	function automatic lead_info_t classify(input logic [7:0] b);
		lead_info_t info;
		info.need    = NEED_STRAY;
		info.payload = '0;
		if (b < LEAD_ASCII_END) begin
			info.need    = NEED_ASCII;
			info.payload = b[6:0];
		end else if (b < LEAD_2_START) begin
			info.need    = NEED_STRAY;
		end else if (b < LEAD_3_START) begin
			info.need    = 3'd1;
			info.payload = {2'b00, b[4:0]};
		end else if (b < LEAD_4_START) begin
			info.need    = 3'd2;
			info.payload = {3'b000, b[3:0]};
		end else if (b < LEAD_5_START) begin
			info.need    = 3'd3;
			info.payload = {4'b0000, b[2:0]};
		end else if (b < LEAD_6_START) begin
			info.need    = 3'd4;
			info.payload = {5'b00000, b[1:0]};
		end else if (b < LEAD_6_END) begin
			info.need    = 3'd5;
			info.payload = {6'b000000, b[0]};
		end
		return info;
	endfunction

endpackage

>>> src/utf8d_byte_if.sv
// ----------------------------------------------------------------------------
// utf8d_byte_if
// Byte channel into the decoder: one raw byte and an end-of-stream flag.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       end_of_stream;

	modport source (output valid, output byte_value, output end_of_stream, input ready);
	modport sink   (input valid, input byte_value, input end_of_stream, output ready);
endinterface

>>> src/utf8d_point_if.sv
// ----------------------------------------------------------------------------
// utf8d_point_if
// Result channel out of the decoder: one code point with its status flags.
// ----------------------------------------------------------------------------
interface utf8d_point_if;
	logic        valid;
	logic        ready;
	logic [30:0] code_point;
	logic        malformed;
	logic        last_of_run;

	modport source (output valid, output code_point, output malformed, output last_of_run,
		input ready);
	modport sink   (input valid, input code_point, input malformed, input last_of_run,
		output ready);
endinterface

>>> src/utf8_byte_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_unit
// UTF-8 decoder for the legacy form of up to six bytes per code point.
// ----------------------------------------------------------------------------
// byte_ch takes one byte per item with an end-of-stream flag. point_ch gives
// decoded code points; malformed marks a stray byte, a bad continuation or a
// truncated sequence, and last_of_run marks the final result of an input byte.
// A lead byte and its continuations give one result, on the last byte of the
// sequence; ASCII and stray bytes give one result each.
// The result is registered: point_ch.valid rises in the cycle after accept.
// In idle a byte is taken every cycle the output register is empty or draining.
// When the stream ends inside a sequence, the held continuation bytes are
// decoded again through the same step unit, one per cycle while the output
// register is free, after a malformed result for the lead; up to four are held,
// and byte_ch.ready stays low until the last result of the run is loaded.
// A stalled receiver holds the output register; byte_ch.ready then drops.
// Reset clears the sequence state, the output valid flag and the replay.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_unit (
	input  logic           clk,
	input  logic           arst_n,
	utf8d_byte_if.sink     byte_ch,
	utf8d_point_if.source  point_ch
);

	localparam logic [2:0] HELD_LIMIT = 3'(utf8d_pkg::HELD_DEPTH);

	utf8d_pkg::state_t    state_q, state_d;
	utf8d_pkg::step_req_t req;
	utf8d_pkg::step_res_t res;

	logic [2:0]                   rem_q;
	logic [utf8d_pkg::CP_W-1:0]   acc_q;
	logic                         bad_q;
	logic [7:0]                   held_q [utf8d_pkg::HELD_DEPTH];
	logic [utf8d_pkg::HELD_IDX_W-1:0] held_count_q;
	logic [utf8d_pkg::HELD_IDX_W-1:0] idx_q;

	logic                         out_valid_q;
	logic [utf8d_pkg::CP_W-1:0]   out_cp_q;
	logic                         out_mal_q;
	logic                         out_last_q;

	logic slot_free, accept, replay_on, replay_go, is_cont;
	logic start_replay, last_replay, load;

	assign slot_free    = !out_valid_q || point_ch.ready;
	assign accept       = byte_ch.valid && byte_ch.ready;
	assign replay_go    = replay_on && slot_free;
	assign is_cont      = rem_q != 3'd0;
	assign start_replay = accept && is_cont && byte_ch.end_of_stream && !res.emit;
	assign last_replay  = idx_q == (held_count_q - 3'd1);
	assign load         = (accept && (res.emit || start_replay)) || (replay_go && res.emit);

	always_comb begin
		req            = '0;
		req.rem        = rem_q;
		req.acc        = acc_q;
		req.bad        = bad_q;
		if (replay_on) begin
			req.byte_value = held_q[idx_q];
			req.limited    = 1'b1;
			req.avail      = held_count_q - 3'd1 - idx_q;
		end else begin
			req.byte_value = byte_ch.byte_value;
			req.limited    = byte_ch.end_of_stream;
			req.avail      = 3'd0;
		end
	end

	utf8d_step u_step (
		.req (req),
		.res (res)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			utf8d_pkg::ST_IDLE: begin
				if (start_replay) state_d = utf8d_pkg::ST_REPLAY;
			end
			utf8d_pkg::ST_REPLAY: begin
				if (slot_free && last_replay) state_d = utf8d_pkg::ST_IDLE;
			end
			default: state_d = utf8d_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		byte_ch.ready = 1'b0;
		replay_on     = 1'b0;
		unique case (state_q)
			utf8d_pkg::ST_IDLE:   byte_ch.ready = slot_free;
			utf8d_pkg::ST_REPLAY: replay_on     = 1'b1;
			default: begin
				byte_ch.ready = 1'b0;
				replay_on     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= utf8d_pkg::ST_IDLE;
			rem_q        <= '0;
			acc_q        <= '0;
			bad_q        <= 1'b0;
			held_count_q <= '0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (point_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (byte_ch.end_of_stream) begin
					rem_q <= '0;
					acc_q <= '0;
					bad_q <= 1'b0;
				end else begin
					rem_q <= res.rem_n;
					acc_q <= res.acc_n;
					bad_q <= res.bad_n;
				end
				// The held count doubles as the replay length after a cut stream.
				if (is_cont && !res.emit) begin
					if (held_count_q < HELD_LIMIT) held_count_q <= held_count_q + 3'd1;
				end else begin
					held_count_q <= '0;
				end
				if (start_replay) idx_q <= '0;
			end else if (replay_go) begin
				idx_q <= idx_q + 3'd1;
				if (last_replay) begin
					rem_q        <= '0;
					acc_q        <= '0;
					bad_q        <= 1'b0;
					held_count_q <= '0;
				end else begin
					rem_q <= res.rem_n;
					acc_q <= res.acc_n;
					bad_q <= res.bad_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_cont && held_count_q < HELD_LIMIT) begin
			held_q[held_count_q] <= byte_ch.byte_value;
		end
		if (load) begin
			out_cp_q   <= start_replay ? '0 : res.code_point;
			out_mal_q  <= start_replay ? 1'b1 : res.malformed;
			out_last_q <= replay_on ? last_replay : !start_replay;
		end
	end

	assign point_ch.valid       = out_valid_q;
	assign point_ch.code_point  = out_cp_q;
	assign point_ch.malformed   = out_mal_q;
	assign point_ch.last_of_run = out_last_q;

endmodule

>>> src/utf8d_step.sv
// ----------------------------------------------------------------------------
// utf8d_step
// One decode step: classifies a lead byte or folds in a continuation byte.
// ----------------------------------------------------------------------------
module utf8d_step (
	input  utf8d_pkg::step_req_t req,
	output utf8d_pkg::step_res_t res
);

	utf8d_pkg::lead_info_t info;
	logic                  cont_bad;

	always_comb begin
		info     = utf8d_pkg::classify(req.byte_value);
		cont_bad = req.bad | (req.byte_value[7:6] != utf8d_pkg::CONT_TAG);
		res            = '0;
		res.rem_n      = req.rem;
		res.acc_n      = req.acc;
		res.bad_n      = req.bad;
		if (req.rem != 3'd0) begin
			res.bad_n = cont_bad;
			res.acc_n = {req.acc[utf8d_pkg::CP_W-7:0], req.byte_value[5:0]};
			res.rem_n = req.rem - 3'd1;
			if (req.rem == 3'd1) begin
				res.emit       = 1'b1;
				res.malformed  = cont_bad;
				res.code_point = cont_bad ? '0
					: {req.acc[utf8d_pkg::CP_W-7:0], req.byte_value[5:0]};
			end
		end else if (info.need == utf8d_pkg::NEED_ASCII) begin
			res.emit       = 1'b1;
			res.code_point = utf8d_pkg::CP_W'(info.payload);
		end else if (info.need == utf8d_pkg::NEED_STRAY
				|| (req.limited && info.need > req.avail)) begin
			// A stray byte, or a lead whose sequence cannot finish before the end.
			res.emit      = 1'b1;
			res.malformed = 1'b1;
		end else begin
			res.rem_n = info.need;
			res.acc_n = utf8d_pkg::CP_W'(info.payload);
			res.bad_n = 1'b0;
		end
	end

endmodule

>>> src/utf8d_checker.sv
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks of the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_eos,
	input logic        out_valid,
	input logic        out_ready,
	input logic [30:0] out_cp,
	input logic        out_mal,
	input logic        out_last
);

	// A result waits until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_cp) && $stable(out_mal) && $stable(out_last))
		else $error("stalled result item changed");

	// The last byte of a stream always closes with at least one result.
	a_eos_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_eos |=> out_valid)
		else $error("end of stream gave no result item");

	// While a run of results is unfinished, no new byte is taken.
	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("byte item taken in the middle of a result run");

	// A malformed result carries code point zero.
	a_mal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_mal |-> out_cp == 31'd0)
		else $error("malformed result item with nonzero code point");

endmodule

bind utf8_byte_stream_decoder_unit utf8d_checker u_utf8d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_ch.valid),
	.in_ready  (byte_ch.ready),
	.in_eos    (byte_ch.end_of_stream),
	.out_valid (point_ch.valid),
	.out_ready (point_ch.ready),
	.out_cp    (point_ch.code_point),
	.out_mal   (point_ch.malformed),
	.out_last  (point_ch.last_of_run)
);
